[hdl/itoa_pkg.sv]
// Shared constants, types and the digit-to-character function for the radix converter.
package itoa_pkg;

  localparam int VALUE_W = 31;   // width of the converted integer
  localparam int RADIX_W = 6;    // width of radix, min_width and max_chars registers
  localparam int CHAR_W  = 8;    // width of one character code
  localparam int DCNT_W  = 5;    // bit counter of the serial divider
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_CHAR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARS = 2'd3;

  // register reset values
  localparam logic [RADIX_W-1:0] RADIX_RST     = 6'd10;
  localparam logic [RADIX_W-1:0] MIN_WIDTH_RST = 6'd0;
  localparam logic [CHAR_W-1:0]  PAD_CHAR_RST  = 8'd32;
  localparam logic [RADIX_W-1:0] MAX_CHARS_RST = 6'd32;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] MAX_DIGIT = 6'd35;
  localparam logic [RADIX_W-1:0] RADIX_MAX = MAX_DIGIT + 6'd1;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A    = 8'h41;

  // divider result, valid on the cycle done is high
  typedef struct packed {
    logic               done;
    logic               busy;
    logic [RADIX_W-1:0] rem;
    logic [VALUE_W-1:0] quot;
  } div_res_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {2'b00, d};
    if (d < DEC_DIGITS) begin
      return ASCII_ZERO + ext;
    end
    return ASCII_A + ext - {2'b00, DEC_DIGITS};
  endfunction

endpackage

[hdl/itoa_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module itoa_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [itoa_pkg::VALUE_W-1:0] dividend,
  input  logic [itoa_pkg::RADIX_W-1:0] divisor,
  output itoa_pkg::div_res_t     res
);
  import itoa_pkg::*;

  logic               busy;
  logic               done;
  logic [DCNT_W-1:0]  cnt;
  logic [VALUE_W-1:0] quot;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W-1:0] dvsr;

  logic [RADIX_W:0]   trial;
  logic [RADIX_W:0]   diff;
  logic               ge;

  assign trial = {rem, quot[VALUE_W-1]};
  assign ge    = trial >= {1'b0, dvsr};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DCNT_W'(1);
        if (cnt == DCNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quot <= {quot[VALUE_W-2:0], ge};
      rem  <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    end
  end

  assign res.done = done;
  assign res.busy = busy;
  assign res.rem  = rem;
  assign res.quot = quot;

endmodule

[hdl/itoa_emit.sv]
// Character buffer and most-significant-first emitter with output register.
module itoa_emit #(
  parameter int MAX_CHARS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [$clog2(MAX_CHARS)-1:0] wr_addr,
  input  logic [itoa_pkg::CHAR_W-1:0] wr_data,
  input  logic                       start,
  input  logic [$clog2(MAX_CHARS+1)-1:0] total,
  input  logic [$clog2(MAX_CHARS+1)-1:0] npad,
  input  logic [itoa_pkg::CHAR_W-1:0] pad_char,
  output logic                       busy,
  output logic                       done,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [itoa_pkg::CHAR_W-1:0] char_code,
  output logic                       last,
  output logic [$clog2(MAX_CHARS+1)-1:0] total_length
);
  import itoa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W = $clog2(MAX_CHARS);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_RD   = 2'd1;
  localparam logic [1:0] E_LD   = 2'd2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  tot;
  logic [CNT_W-1:0]  np;
  logic [CHAR_W-1:0] pad;
  logic [CHAR_W-1:0] mem [MAX_CHARS];
  logic [CHAR_W-1:0] rd_data;

  logic [CNT_W-1:0]  rd_full;
  logic              in_pad;
  logic              is_last;
  logic              load;

  assign rd_full = tot - CNT_W'(1) - k;
  assign in_pad  = k < np;
  assign is_last = k == tot - CNT_W'(1);
  assign load    = (state == E_LD) && (!out_valid || !out_stall);
  assign busy    = state != E_IDLE;
  assign done    = load && is_last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == E_RD && !in_pad) begin
      rd_data <= mem[rd_full[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a load refills the output register in the same cycle it drains
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        E_IDLE: begin
          if (start) begin
            state <= E_RD;
          end
        end
        E_RD: begin
          state <= E_LD;
        end
        E_LD: begin
          if (load) begin
            state <= is_last ? E_IDLE : E_RD;
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && start) begin
      tot <= total;
      np  <= npad;
      pad <= pad_char;
      k   <= '0;
    end else if (load) begin
      k <= k + CNT_W'(1);
    end
    if (load) begin
      char_code    <= in_pad ? pad : rd_data;
      last         <= is_last;
      total_length <= tot;
    end
  end

endmodule

[hdl/radix_integer_to_ascii_top.sv]
// Top level of the radix integer-to-ASCII converter: registers, digit loop, emitter.
// Converts one non-negative 31-bit value per input word into ASCII digits in base
// radix (2..36, clamped), digits 0-9 as '0'-'9' and 10-35 as 'A'-'Z', always at least
// one digit. At most max_chars characters (clamped to 1..MAX_CHARS) come out; when the
// value needs more, only the low-order digits are kept. Fewer digits than min_width
// (capped at the limit) get pad_char in front. Characters leave most significant first,
// one per output word, with last set on the final one and total_length on all.
// Sequence: each digit comes from the bit-serial divider, one quotient bit per cycle
// over 31 bits, between a start state and a hand-off; each character then needs a
// buffer read and an output load, and the load waits while the output is stalled.
// A new value is taken only after the previous conversion has loaded its last
// character into the output register, which may still be waiting to be taken.
// Config writes are for idle periods.
module radix_integer_to_ascii_top #(
  parameter int MAX_CHARS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [itoa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [itoa_pkg::CHAR_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [itoa_pkg::VALUE_W-1:0]   value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [itoa_pkg::CHAR_W-1:0]    char_code,
  output logic                           last,
  output logic [$clog2(MAX_CHARS+1)-1:0] total_length
);
  import itoa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W = $clog2(MAX_CHARS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // configuration registers
  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] min_width;
  logic [CHAR_W-1:0]  pad_char;
  logic [RADIX_W-1:0] max_chars;

  logic [2:0]         state;
  logic [VALUE_W-1:0] quotient_work;
  logic [CNT_W-1:0]   ndig;

  logic [RADIX_W-1:0] base;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   width_eff;
  logic [CNT_W-1:0]   npad;
  logic [CNT_W-1:0]   ndig_next;
  logic               more;

  logic               div_start;
  div_res_t           div_res;
  logic               wr_en;
  logic               emit_start;
  logic               emit_busy;
  logic               emit_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= RADIX_RST;
      min_width <= MIN_WIDTH_RST;
      pad_char  <= PAD_CHAR_RST;
      max_chars <= MAX_CHARS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX:     radix     <= cfg_data[RADIX_W-1:0];
        REG_MIN_WIDTH: min_width <= cfg_data[RADIX_W-1:0];
        REG_PAD_CHAR:  pad_char  <= cfg_data;
        REG_MAX_CHARS: max_chars <= cfg_data[RADIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamped base and character limit, effective minimum width and pad count
  always_comb begin
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
    if (max_chars == '0) begin
      limit = CNT_W'(1);
    end else if ({1'b0, max_chars} > 7'(MAX_CHARS)) begin
      limit = CNT_W'(MAX_CHARS);
    end else begin
      limit = CNT_W'(max_chars);
    end
    if ({1'b0, min_width} > 7'(limit)) begin
      width_eff = limit;
    end else begin
      width_eff = CNT_W'(min_width);
    end
    npad = (width_eff > ndig) ? width_eff - ndig : '0;
  end

  assign ndig_next  = ndig + CNT_W'(1);
  assign more       = (div_res.quot != '0) && (ndig_next < limit);
  assign in_stall   = state != S_IDLE;
  assign div_start  = state == S_START;
  assign wr_en      = (state == S_DIV) && div_res.done;
  assign emit_start = state == S_FIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_res.done) begin
            state <= more ? S_START : S_FIN;
          end
        end
        S_FIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      quotient_work <= value;
      ndig          <= '0;
    end else if (wr_en) begin
      quotient_work <= div_res.quot;
      ndig          <= ndig_next;
    end
  end

  itoa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (quotient_work),
    .divisor  (base),
    .res      (div_res)
  );

  // digits land low-order first at index ndig; the emitter reads them back reversed
  itoa_emit #(
    .MAX_CHARS (MAX_CHARS)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_addr      (ndig[ADDR_W-1:0]),
    .wr_data      (digit_ascii(div_res.rem)),
    .start        (emit_start),
    .total        (npad + ndig),
    .npad         (npad),
    .pad_char     (pad_char),
    .busy         (emit_busy),
    .done         (emit_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_code    (char_code),
    .last         (last),
    .total_length (total_length)
  );

`ifndef SYNTHESIS
  a_ndig_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (ndig < limit))
    else $error("digit count reached limit while dividing");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_res.busy)
    else $error("divider started while busy");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !emit_busy)
    else $error("emitter busy while converter idle");
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (total_length != '0))
    else $error("output word with zero length");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (div_res.rem < base))
    else $error("remainder not below base");
`endif

endmodule
